FILE: design/rldu_pkg.sv
// Shared types, constants and helpers for the subpicture RLE run decoder.
// Used by rldu_nibble, rldu_out_fifo and subpicture_rle_run_decoder_unit.
package rldu_pkg;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned INDEX_W   = 2;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned PEND_W    = 3;
  localparam int unsigned RUN_W     = CODE_W - INDEX_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Nibble counts of the four code lengths
  localparam logic [PEND_W-1:0] PEND_4BIT  = 3'd1;
  localparam logic [PEND_W-1:0] PEND_8BIT  = 3'd2;
  localparam logic [PEND_W-1:0] PEND_12BIT = 3'd3;
  localparam logic [PEND_W-1:0] PEND_16BIT = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_PALETTE_0    = 3'd2,
    CFG_PALETTE_1    = 3'd3,
    CFG_PALETTE_2    = 3'd4,
    CFG_PALETTE_3    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] rle_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] run_color;
    logic [INDEX_W-1:0] palette_slot;
    logic [DIM_W-1:0]   pixel_count;
    logic [DIM_W-1:0]   row_number;
    logic [DIM_W-1:0]   start_column;
    logic               is_background;
    logic               end_of_row;
    logic               end_of_frame;
    logic               last_of_byte;
  } out_item_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [CODE_W-1:0]  code_bits;
    logic [PEND_W-1:0]  pending_nibbles;
    logic [DIM_W-1:0]   column_count;
    logic [DIM_W-1:0]   row_count;
    logic [INDEX_W-1:0] background_index;
    logic               frame_done;
  } dec_state_t;

  // One decoded run as a nibble slice reports it
  typedef struct packed {
    logic [INDEX_W-1:0] palette_slot;
    logic [DIM_W-1:0]   pixel_count;
    logic [DIM_W-1:0]   row_number;
    logic [DIM_W-1:0]   start_column;
    logic               is_background;
    logic               end_of_row;
    logic               end_of_frame;
  } run_t;

  function automatic logic [COLOR_W-1:0] pick_color(
    input logic [INDEX_W-1:0] idx,
    input logic [COLOR_W-1:0] c0,
    input logic [COLOR_W-1:0] c1,
    input logic [COLOR_W-1:0] c2,
    input logic [COLOR_W-1:0] c3
  );
    logic [COLOR_W-1:0] c;
    unique case (idx)
      2'd0:    c = c0;
      2'd1:    c = c1;
      2'd2:    c = c2;
      default: c = c3;
    endcase
    return c;
  endfunction

endpackage

FILE: design/rldu_nibble.sv
// One nibble step of the run decoder: extends the current code, finishes it
// when complete and reports the clipped run. Depends on rldu_pkg.
module rldu_nibble (
  input  rldu_pkg::dec_state_t st_i,
  input  logic [3:0]           nib_i,
  input  logic                 active_i,
  input  logic [11:0]          width_i,
  input  logic [11:0]          height_i,
  output rldu_pkg::dec_state_t st_o,
  output logic                 emit_o,
  output rldu_pkg::run_t       run_o,
  output logic                 cont_o
);
  import rldu_pkg::*;

  logic [CODE_W-1:0]  code_n;
  logic [PEND_W-1:0]  pend_n;
  logic               finish;
  logic [RUN_W-1:0]   run;
  logic [INDEX_W-1:0] idx;
  logic               fill;
  logic [DIM_W-1:0]   remain;
  logic [DIM_W-1:0]   len;
  logic [DIM_W-1:0]   col_n;
  logic [DIM_W-1:0]   row_n;
  logic               eor;
  logic               eof;
  logic [INDEX_W-1:0] bg_n;

  always_comb begin
    code_n = {st_i.code_bits[CODE_W-5:0], nib_i};
    pend_n = st_i.pending_nibbles + 3'd1;
    case (pend_n)
      PEND_4BIT:  finish = |code_n[CODE_W-1:2];
      PEND_8BIT:  finish = |code_n[CODE_W-1:4];
      PEND_12BIT: finish = |code_n[CODE_W-1:6];
      default:    finish = 1'b1;
    endcase
    run    = code_n[CODE_W-1:INDEX_W];
    idx    = code_n[INDEX_W-1:0];
    fill   = (pend_n == PEND_16BIT) && (run == '0);
    remain = width_i - st_i.column_count;
    // clip to the rest of the row; a zero run field fills it
    len    = (fill || (run > {2'b00, remain})) ? remain : run[DIM_W-1:0];
    col_n  = st_i.column_count + len;
    eor    = (col_n == width_i);
    row_n  = st_i.row_count + 12'd1;
    eof    = eor && (({1'b0, st_i.row_count} + 13'd1) >= {1'b0, height_i});
    bg_n   = ((st_i.column_count == '0) && (st_i.row_count == '0)) ? idx
                                                                   : st_i.background_index;

    st_o   = st_i;
    emit_o = 1'b0;
    cont_o = 1'b0;
    run_o  = '0;

    if (active_i && !st_i.frame_done) begin
      if (st_i.row_count >= height_i) begin
        st_o.frame_done = 1'b1;
      end else if (!finish) begin
        st_o.code_bits       = code_n;
        st_o.pending_nibbles = pend_n;
        cont_o               = 1'b1;
      end else begin
        st_o.code_bits       = '0;
        st_o.pending_nibbles = '0;
        if (st_i.column_count >= width_i) begin
          // row already full: drop the code and the rest of the byte
          st_o.column_count = '0;
          st_o.row_count    = row_n;
          st_o.frame_done   = (row_n >= height_i);
        end else begin
          emit_o                = 1'b1;
          st_o.background_index = bg_n;
          run_o.palette_slot    = idx;
          run_o.pixel_count     = len;
          run_o.row_number      = st_i.row_count;
          run_o.start_column    = st_i.column_count;
          run_o.is_background   = (idx == bg_n);
          run_o.end_of_row      = eor;
          run_o.end_of_frame    = eof;
          if (eor) begin
            st_o.column_count = '0;
            st_o.row_count    = row_n;
            st_o.frame_done   = (row_n >= height_i);
          end else begin
            st_o.column_count = col_n;
            cont_o            = 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: design/rldu_out_fifo.sv
// Small result queue: takes up to two items per cycle, hands out one.
// Depends on rldu_pkg for the item type and depth.
module rldu_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           wr_cnt_i,
  input  rldu_pkg::out_item_t  wr_data0_i,
  input  rldu_pkg::out_item_t  wr_data1_i,
  input  logic                 rd_ready_i,
  output logic                 rd_valid_o,
  output rldu_pkg::out_item_t  rd_data_o,
  output logic [rldu_pkg::OUT_CNT_W-1:0] count_o
);
  import rldu_pkg::*;

  out_item_t              mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0]   count_r, count_nxt;
  logic                   rd_en;
  logic [OUT_PTR_W-1:0]   wr_ptr_p1;

  assign rd_valid_o = (count_r != '0);
  assign rd_data_o  = mem_r[rd_ptr_r];
  assign count_o    = count_r;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign wr_ptr_p1  = wr_ptr_r + OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(wr_cnt_i);
    rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(rd_en);
    count_nxt  = count_r + OUT_CNT_W'(wr_cnt_i) - OUT_CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt_i != 2'd0) begin
      mem_r[wr_ptr_r] <= wr_data0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_r[wr_ptr_p1] <= wr_data1_i;
    end
  end

endmodule

FILE: design/subpicture_rle_run_decoder_unit.sv
// Subpicture RLE run decoder: top level with input register, decode slices
// and result queue. Depends on rldu_pkg, rldu_nibble and rldu_out_fifo.
//
// Takes one coded byte per cycle and emits zero, one or two runs for it.
// A byte sits in the input register, where two nibble slices
// decode it against the stored state; its runs then go into a four-entry
// result queue. A new byte is taken every cycle as long as the queue has
// room for two runs, so the sustained rate is one byte per cycle, bounded
// only by the output side when bytes yield two runs each. Image size and
// palette must be written while the block is idle; width or height zero
// turns decoding off.
module subpicture_rle_run_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rldu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rldu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [rldu_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rldu_pkg::COLOR_W-1:0]   cfg_wdata
);
  import rldu_pkg::*;

  logic [DIM_W-1:0]   width_r, height_r;
  logic [COLOR_W-1:0] pal0_r, pal1_r, pal2_r, pal3_r;

  logic               in_valid_r, in_valid_nxt;
  in_item_t           in_data_r;
  dec_state_t         state_r, state_nxt;
  dec_state_t         st_start, st0, st1;
  logic               fire;
  logic               enabled;
  logic               emit0, emit1, cont0, cont1;
  run_t               run0, run1;
  out_item_t          item0, item1, wr0;
  logic [1:0]         wr_cnt;
  logic [OUT_CNT_W-1:0] fifo_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      pal0_r   <= '0;
      pal1_r   <= '0;
      pal2_r   <= '0;
      pal3_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_PALETTE_0:    pal0_r   <= cfg_wdata;
        CFG_PALETTE_1:    pal1_r   <= cfg_wdata;
        CFG_PALETTE_2:    pal2_r   <= cfg_wdata;
        CFG_PALETTE_3:    pal3_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decode the held byte only when the queue can take two runs
  assign fire     = in_valid_r && (fifo_count <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign in_ready = !in_valid_r || fire;
  assign enabled  = (width_r != '0) && (height_r != '0);

  always_comb begin
    st_start = state_r;
    if (in_data_r.frame_start) begin
      st_start.code_bits       = '0;
      st_start.pending_nibbles = '0;
      st_start.column_count    = '0;
      st_start.row_count       = '0;
      st_start.frame_done      = 1'b0;
    end
  end

  rldu_nibble u_hi (
    .st_i     (st_start),
    .nib_i    (in_data_r.rle_byte[7:4]),
    .active_i (enabled),
    .width_i  (width_r),
    .height_i (height_r),
    .st_o     (st0),
    .emit_o   (emit0),
    .run_o    (run0),
    .cont_o   (cont0)
  );

  rldu_nibble u_lo (
    .st_i     (st0),
    .nib_i    (in_data_r.rle_byte[3:0]),
    .active_i (cont0),
    .width_i  (width_r),
    .height_i (height_r),
    .st_o     (st1),
    .emit_o   (emit1),
    .run_o    (run1),
    .cont_o   (cont1)
  );

  always_comb begin
    item0.run_color     = pick_color(run0.palette_slot, pal0_r, pal1_r, pal2_r, pal3_r);
    item0.palette_slot  = run0.palette_slot;
    item0.pixel_count   = run0.pixel_count;
    item0.row_number    = run0.row_number;
    item0.start_column  = run0.start_column;
    item0.is_background = run0.is_background;
    item0.end_of_row    = run0.end_of_row;
    item0.end_of_frame  = run0.end_of_frame;
    item0.last_of_byte  = !emit1;

    item1.run_color     = pick_color(run1.palette_slot, pal0_r, pal1_r, pal2_r, pal3_r);
    item1.palette_slot  = run1.palette_slot;
    item1.pixel_count   = run1.pixel_count;
    item1.row_number    = run1.row_number;
    item1.start_column  = run1.start_column;
    item1.is_background = run1.is_background;
    item1.end_of_row    = run1.end_of_row;
    item1.end_of_frame  = run1.end_of_frame;
    item1.last_of_byte  = 1'b1;

    wr0    = emit0 ? item0 : item1;
    wr_cnt = fire ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
  end

  always_comb begin
    state_nxt    = fire ? st1 : state_r;
    in_valid_nxt = in_ready ? in_valid : in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      state_r    <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  rldu_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_cnt_i   (wr_cnt),
    .wr_data0_i (wr0),
    .wr_data1_i (item1),
    .rd_ready_i (out_ready),
    .rd_valid_o (out_valid),
    .rd_data_o  (out_data),
    .count_o    (fifo_count)
  );

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result queue not empty after reset");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && state_r.frame_done && !in_data_r.frame_start |-> wr_cnt == 2'd0)
    else $error("run emitted after frame finished");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pixel_count != '0)
    else $error("zero length run");

  a_eof_at_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_frame |-> out_data.end_of_row)
    else $error("end of frame without end of row");

endmodule

FILE: tb/sv/rldu_run_checker.sv
// Run checker for the subpicture RLE run decoder: tracks configuration and
// decode state, predicts the runs of every accepted byte and matches them
// in order against the result channel. Depends on rldu_pkg.
module rldu_run_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rldu_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rldu_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [rldu_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rldu_pkg::COLOR_W-1:0]   cfg_wdata,
  output int                             mismatch_count,
  output int                             pending_runs
);
  import rldu_pkg::*;

  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [COLOR_W-1:0] palette [4];
  logic [CODE_W-1:0]  code_acc;
  logic [PEND_W-1:0]  nib_cnt;
  logic [DIM_W-1:0]   col_cnt;
  logic [DIM_W-1:0]   row_cnt;
  logic [INDEX_W-1:0] bg_idx;
  logic               frame_over;
  out_item_t          expected_runs[$];

  function automatic string run_text(input out_item_t r);
    return $sformatf("color=%06h idx=%0d len=%0d row=%0d col=%0d bg=%b eor=%b eof=%b last=%b",
                     r.run_color, r.palette_slot, r.pixel_count, r.row_number,
                     r.start_column, r.is_background, r.end_of_row, r.end_of_frame,
                     r.last_of_byte);
  endfunction

  task automatic close_current_row();
    col_cnt = '0;
    row_cnt = row_cnt + 1'b1;
    if (row_cnt >= height_reg) frame_over = 1'b1;
  endtask

  // Decode both nibbles of one byte and queue the runs it finishes
  task automatic predict_runs(input in_item_t item);
    out_item_t          runs [2];
    out_item_t          r;
    logic [3:0]         nib;
    logic [RUN_W-1:0]   run_field;
    logic [INDEX_W-1:0] idx;
    logic               fill;
    logic [DIM_W-1:0]   remain;
    logic [DIM_W-1:0]   len;
    logic [DIM_W-1:0]   start;
    logic               row_end;
    int                 produced;
    bit                 stop;
    produced = 0;
    stop = 1'b0;
    if (item.frame_start) begin
      code_acc = '0;
      nib_cnt = '0;
      col_cnt = '0;
      row_cnt = '0;
      frame_over = 1'b0;
    end
    if (width_reg == 0 || height_reg == 0) return;
    for (int half = 0; half < 2 && !stop; half++) begin
      if (frame_over) begin
        stop = 1'b1;
      end else if (row_cnt >= height_reg) begin
        frame_over = 1'b1;
        stop = 1'b1;
      end else begin
        nib = (half == 0) ? item.rle_byte[7:4] : item.rle_byte[3:0];
        code_acc = {code_acc[CODE_W-5:0], nib};
        nib_cnt = nib_cnt + 1'b1;
        // a code is done once its run field is nonzero or it is 16 bits long
        if (nib_cnt == PEND_16BIT || (code_acc >> (2 * nib_cnt)) != 0) begin
          run_field = code_acc[CODE_W-1:INDEX_W];
          idx = code_acc[INDEX_W-1:0];
          fill = (nib_cnt == PEND_16BIT) && (run_field == 0);
          code_acc = '0;
          nib_cnt = '0;
          if (col_cnt >= width_reg) begin
            // width shrunk under the current column: end the row, drop the rest
            close_current_row();
            stop = 1'b1;
          end else begin
            remain = width_reg - col_cnt;
            len = (fill || run_field > remain) ? remain : run_field[DIM_W-1:0];
            if (col_cnt == 0 && row_cnt == 0) bg_idx = idx;
            start = col_cnt;
            col_cnt = col_cnt + len;
            row_end = (col_cnt == width_reg);
            r.run_color = palette[idx];
            r.palette_slot = idx;
            r.pixel_count = len;
            r.row_number = row_cnt;
            r.start_column = start;
            r.is_background = (idx == bg_idx);
            r.end_of_row = row_end;
            r.end_of_frame = row_end && ({1'b0, row_cnt} + 13'd1 >= {1'b0, height_reg});
            r.last_of_byte = 1'b0;
            runs[produced] = r;
            produced++;
            if (row_end) begin
              close_current_row();
              stop = 1'b1;
            end
          end
        end
      end
    end
    for (int k = 0; k < produced; k++) begin
      r = runs[k];
      r.last_of_byte = (k == produced - 1);
      expected_runs.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      width_reg = '0;
      height_reg = '0;
      for (int p = 0; p < 4; p++) palette[p] = '0;
      code_acc = '0;
      nib_cnt = '0;
      col_cnt = '0;
      row_cnt = '0;
      bg_idx = '0;
      frame_over = 1'b0;
      expected_runs.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IMAGE_WIDTH:  width_reg = cfg_wdata[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[DIM_W-1:0];
          CFG_PALETTE_0:    palette[0] = cfg_wdata;
          CFG_PALETTE_1:    palette[1] = cfg_wdata;
          CFG_PALETTE_2:    palette[2] = cfg_wdata;
          CFG_PALETTE_3:    palette[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_runs(in_data);
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected run: %s", run_text(out_data));
          mismatch_count++;
        end else begin
          want = expected_runs.pop_front();
          if (out_data !== want) begin
            if (mismatch_count < 10)
              $display("run mismatch\n  expected %s\n  actual   %s",
                       run_text(want), run_text(out_data));
            mismatch_count++;
          end
        end
      end
    end
    pending_runs = expected_runs.size();
  end

endmodule

FILE: tb/sv/tb_subpicture_rle_run_decoder_unit.sv
// Testbench top for subpicture_rle_run_decoder_unit: builds coded frames and
// noise bytes, drives them with random gaps and stalls, and gives the verdict.
// Depends on rldu_pkg, rldu_run_checker and the decoder RTL.
module tb_subpicture_rle_run_decoder_unit;
  import rldu_pkg::*;

  localparam int FRAME_BYTE_TARGET = 1100;
  localparam int CALM_AFTER        = 900;
  localparam int DRAIN_CYCLES      = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [COLOR_W-1:0]   cfg_wdata = '0;
  int                   mismatch_count;
  int                   pending_runs;

  in_item_t             byte_q[$];
  logic [3:0]           held_nibble;
  bit                   nibble_held = 1'b0;
  bit                   mark_frame_start = 1'b0;
  int                   frame_bytes = 0;
  bit                   calm = 1'b0;
  bit                   in_gaps_on = 1'b1;
  bit                   out_stalls_on = 1'b1;
  int                   stall_left = 0;

  subpicture_rle_run_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  rldu_run_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_runs   (pending_runs)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("subpicture_rle_run_decoder_unit verification failed");
    $finish;
  end

  // Result side: random stall bursts while stalls are on and traffic is not calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && out_stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_byte(input logic [7:0] value, input bit start);
    in_item_t item;
    item.rle_byte = value;
    item.frame_start = start;
    byte_q.push_back(item);
    frame_bytes++;
  endtask

  task automatic put_nibble(input logic [3:0] nib);
    if (!nibble_held) begin
      held_nibble = nib;
      nibble_held = 1'b1;
    end else begin
      queue_byte({held_nibble, nib}, mark_frame_start);
      mark_frame_start = 1'b0;
      nibble_held = 1'b0;
    end
  endtask

  task automatic queue_code(input int run, input int idx, input int nibs);
    logic [CODE_W-1:0] code;
    code = {run[RUN_W-1:0], idx[INDEX_W-1:0]};
    for (int k = nibs - 1; k >= 0; k--) put_nibble(code[4*k +: 4]);
  endtask

  // Well-formed coded rows; the last row may be cut after its first code
  task automatic queue_frame(input int w, input int h, input int max_rows, input bit cut_last);
    int rows;
    int col;
    int remain;
    int run;
    int nibs;
    int kind;
    rows = (h < max_rows) ? h : max_rows;
    mark_frame_start = 1'b1;
    for (int r = 0; r < rows; r++) begin
      col = 0;
      while (col < w) begin
        remain = w - col;
        kind = $urandom_range(0, 9);
        // wide rows: lean on long codes so a row stays a few bytes
        if (remain > 200 && kind > 4) kind = $urandom_range(0, 2);
        case (kind)
          0:       run = 0;
          1:       run = remain + $urandom_range(1, 80);
          2:       run = $urandom_range(64, 16383);
          3:       run = $urandom_range(16, 63);
          4, 5:    run = $urandom_range(4, 15);
          default: run = $urandom_range(1, 3);
        endcase
        if (run == 0 || run >= 64) nibs = 4;
        else if (run >= 16) nibs = 3;
        else if (run >= 4) nibs = 2;
        else nibs = 1;
        // literal run in the 16-bit form
        if (nibs < 4 && $urandom_range(0, 7) == 0) nibs = 4;
        queue_code(run, $urandom_range(0, 3), nibs);
        col = (run == 0 || run >= remain) ? w : col + run;
        if (cut_last && r == rows - 1) break;
      end
      // pad to the byte boundary; after a full row the decoder drops this nibble
      if (nibble_held) put_nibble(4'($urandom_range(0, 15)));
    end
  endtask

  task automatic queue_noise(input int count, input bit with_starts);
    for (int k = 0; k < count; k++)
      queue_byte(8'($urandom_range(0, 255)), with_starts && $urandom_range(0, 7) == 0);
  endtask

  task automatic send_item(input in_item_t item);
    if (!calm && in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_queued();
    while (byte_q.size() != 0) begin
      send_item(byte_q.pop_front());
      if (frame_bytes >= CALM_AFTER) calm <= 1'b1;
    end
    in_valid <= 1'b0;
  endtask

  // Wait for every predicted run, then let bytes without runs clear the pipe
  task automatic wait_drained();
    do @(negedge clk); while (pending_runs != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [COLOR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic write_config(input int w, input int h);
    logic [COLOR_W-1:0] color;
    // upper bits of the size registers carry junk that must be ignored
    write_reg(CFG_IMAGE_WIDTH, {12'($urandom_range(0, 4095)), w[DIM_W-1:0]});
    write_reg(CFG_IMAGE_HEIGHT, {12'($urandom_range(0, 4095)), h[DIM_W-1:0]});
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 3))
        0:       color = 24'h000000;
        1:       color = 24'hFFFFFF;
        default: color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
      endcase
      write_reg(cfg_idx_t'(CFG_PALETTE_0 + p), color);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int w;
    int h;
    int kind;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Code lengths, clipping, fill and a finished frame
    write_config(20, 2);
    mark_frame_start = 1'b1;
    queue_code(1, 0, 1);
    queue_code(3, 3, 1);
    queue_code(4, 1, 2);
    queue_code(15, 2, 2);
    queue_code(16, 0, 3);
    queue_code(2, 1, 4);
    queue_code(0, 3, 4);
    put_nibble(4'h9);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    send_queued();
    wait_drained();

    // Decoding off by width, then by height
    write_config(0, 3);
    queue_byte(8'h5A, 1'b1);
    queue_byte(8'hA5, 1'b0);
    send_queued();
    wait_drained();
    write_config(4095, 0);
    queue_byte(8'h11, 1'b0);
    send_queued();
    wait_drained();

    // Largest image: longest run clipped to a full row
    write_config(4095, 4095);
    mark_frame_start = 1'b1;
    queue_code(16383, 3, 4);
    queue_code(0, 2, 4);
    queue_code(3, 1, 1);
    put_nibble(4'h0);
    send_queued();

    while (frame_bytes < FRAME_BYTE_TARGET) begin
      wait_drained();
      in_gaps_on <= ($urandom_range(0, 3) != 0);
      out_stalls_on <= ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        w = $urandom_range(0, 1) ? 4095 : 1;
        h = $urandom_range(0, 1) ? 4095 : 1;
        write_config(w, h);
        queue_frame(w, h, (w == 1) ? 40 : 2, 1'b0);
        queue_noise($urandom_range(0, 2), 1'b0);
      end else if (kind == 1) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
        h = (w == 0) ? $urandom_range(0, 6) : 0;
        write_config(w, h);
        queue_noise($urandom_range(4, 12), 1'b1);
      end else if (kind == 2) begin
        // stop mid-frame, shrink width or height, then continue with raw bytes
        w = $urandom_range(8, 40);
        h = $urandom_range(2, 6);
        write_config(w, h);
        queue_frame(w, h, $urandom_range(1, h), 1'b1);
        send_queued();
        wait_drained();
        if ($urandom_range(0, 1)) write_reg(CFG_IMAGE_WIDTH, COLOR_W'($urandom_range(1, w)));
        else write_reg(CFG_IMAGE_HEIGHT, COLOR_W'($urandom_range(1, h)));
        cfg_we <= 1'b0;
        queue_noise($urandom_range(4, 10), 1'b0);
      end else begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 6);
        write_config(w, h);
        repeat ($urandom_range(1, 3)) begin
          queue_frame(w, h, h, 1'b0);
          queue_noise($urandom_range(0, 2), 1'b0);
        end
        if ($urandom_range(0, 5) == 0) queue_noise($urandom_range(3, 8), 1'b1);
      end
      send_queued();
    end

    wait_drained();
    @(negedge clk);
    if (mismatch_count == 0 && pending_runs == 0) begin
      $display("subpicture_rle_run_decoder_unit verification clean");
    end else begin
      $display("subpicture_rle_run_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: subpicture_rle_run_decoder_unit.f
design/rldu_pkg.sv
design/rldu_nibble.sv
design/rldu_out_fifo.sv
design/subpicture_rle_run_decoder_unit.sv
tb/sv/rldu_run_checker.sv
tb/sv/tb_subpicture_rle_run_decoder_unit.sv
